### rtl/apb_pkg.sv
// shared types and constants for the premultiplied argb pixel blender
// no dependencies; used by the datapath and the top level

package apb_pkg;

  localparam int unsigned PixW    = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = PixW / ChanW;
  localparam int unsigned ProdW   = 2 * ChanW;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 32;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLEND_MODE  = 4'd0,
    REG_SOURCE_KIND = 4'd1,
    REG_SOLID_COLOR = 4'd2,
    REG_OPACITY     = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    BLEND_SOURCE      = 1'b0,
    BLEND_SOURCE_OVER = 1'b1
  } blend_mode_e;

  typedef enum logic {
    SRC_SOLID = 1'b0,
    SRC_PIXEL = 1'b1
  } source_kind_e;

  // what the last stage does with the operands
  typedef enum logic [1:0] {
    OP_PASS_S = 2'd0,
    OP_PASS_D = 2'd1,
    OP_LERP   = 2'd2,
    OP_ADD    = 2'd3
  } blend_op_e;

  localparam blend_mode_e      RstBlendMode  = BLEND_SOURCE_OVER;
  localparam source_kind_e     RstSourceKind = SRC_PIXEL;
  localparam logic [PixW-1:0]  RstSolidColor = 32'h0000_0000;
  localparam logic [ChanW-1:0] RstOpacity    = 8'hFF;

  typedef struct packed {
    logic [PixW-1:0] dest_pixel;
    logic [PixW-1:0] source_pixel;
    logic            end_of_span;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] result_pixel;
    logic            end_of_span_out;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    blend_mode_e      blend_mode;
    source_kind_e     source_kind;
    logic [PixW-1:0]  solid_color;
    logic [ChanW-1:0] opacity;
  } blend_cfg_t;

  // occupancy of the three pipeline stages
  typedef struct packed {
    logic v1;
    logic v2;
    logic v3;
  } pipe_stat_t;

endpackage

### rtl/apb_chan_if.sv
// valid/ready channel carrying one payload struct per transaction
// payload type comes from apb_pkg at the point of instantiation

interface apb_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/apb_datapath.sv
// three-stage blend pipeline: decode and source scaling, destination scaling, combine
// depends on apb_pkg and apb_chan_if

module apb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  apb_pkg::blend_cfg_t cfg,
  apb_chan_if.sink            in_chan,
  apb_chan_if.source          out_chan,
  output apb_pkg::pipe_stat_t stat
);

  typedef struct packed {
    apb_pkg::blend_op_e        op;
    logic                      scale;
    logic                      b_from_c;
    logic [apb_pkg::ChanW-1:0] ca;
    logic                      eos;
  } ctl_t;

  // stage 1: decoded control, source bytes times constant alpha
  logic                                              v1_r;
  ctl_t                                              ctl1_r, ctl1_nxt;
  logic [apb_pkg::PixW-1:0]                          d1_r;
  logic [apb_pkg::PixW-1:0]                          s1_r, s_sel;
  logic [apb_pkg::NumChan-1:0][apb_pkg::ProdW-1:0]   ps1_r, ps1_nxt;

  // stage 2: scaled source, destination bytes times destination factor
  logic                                              v2_r;
  apb_pkg::blend_op_e                                op2_r;
  logic                                              eos2_r;
  logic [apb_pkg::PixW-1:0]                          d2_r;
  logic [apb_pkg::PixW-1:0]                          c2_r, c2_nxt;
  logic [apb_pkg::NumChan-1:0][apb_pkg::ProdW-1:0]   ps2_r;
  logic [apb_pkg::NumChan-1:0][apb_pkg::ProdW-1:0]   pd2_r, pd2_nxt;
  logic [apb_pkg::ChanW-1:0]                         dfac;

  // stage 3: output register
  logic                                              v3_r;
  logic [apb_pkg::PixW-1:0]                          res3_r, res3_nxt;
  logic                                              eos3_r;
  logic [apb_pkg::PixW-1:0]                          dscaled, lerp_pix;
  logic [apb_pkg::NumChan-1:0][apb_pkg::ProdW:0]     lerp_sum;

  logic rdy1, rdy2, rdy3;
  logic ca_full;

  assign rdy3 = !v3_r || out_chan.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  // ---- stage 1 ----
  assign s_sel   = (cfg.source_kind == apb_pkg::SRC_PIXEL) ? in_chan.payload.source_pixel
                                                           : cfg.solid_color;
  assign ca_full = (cfg.opacity == apb_pkg::ChanMax);

  always_comb begin
    ctl1_nxt.ca       = cfg.opacity;
    ctl1_nxt.eos      = in_chan.payload.end_of_span;
    ctl1_nxt.op       = apb_pkg::OP_ADD;
    ctl1_nxt.scale    = 1'b1;
    ctl1_nxt.b_from_c = 1'b0;
    priority if (cfg.blend_mode == apb_pkg::BLEND_SOURCE) begin
      priority if (ca_full) begin
        ctl1_nxt.op    = apb_pkg::OP_PASS_S;
        ctl1_nxt.scale = 1'b0;
      end else if (cfg.source_kind == apb_pkg::SRC_PIXEL) begin
        ctl1_nxt.op = apb_pkg::OP_LERP;
      end else begin
        ctl1_nxt.op = apb_pkg::OP_ADD;
      end
    end else begin
      ctl1_nxt.b_from_c = 1'b1;
      priority if (!ca_full) begin
        ctl1_nxt.op = apb_pkg::OP_ADD;
      end else if (cfg.source_kind == apb_pkg::SRC_SOLID) begin
        ctl1_nxt.scale = 1'b0;
      end else if (s_sel[apb_pkg::PixW-1 -: apb_pkg::ChanW] == apb_pkg::ChanMax) begin
        // opaque source replaces the destination
        ctl1_nxt.op    = apb_pkg::OP_PASS_S;
        ctl1_nxt.scale = 1'b0;
      end else if (s_sel == '0) begin
        ctl1_nxt.op    = apb_pkg::OP_PASS_D;
        ctl1_nxt.scale = 1'b0;
      end else begin
        ctl1_nxt.scale = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < apb_pkg::NumChan; i++) begin
      ps1_nxt[i] = apb_pkg::ProdW'(s_sel[apb_pkg::ChanW*i +: apb_pkg::ChanW])
                 * apb_pkg::ProdW'(cfg.opacity);
    end
  end

  // ---- stage 2 ----
  always_comb begin
    for (int i = 0; i < apb_pkg::NumChan; i++) begin
      c2_nxt[apb_pkg::ChanW*i +: apb_pkg::ChanW] =
        ctl1_r.scale ? ps1_r[i][apb_pkg::ProdW-1 -: apb_pkg::ChanW]
                     : s1_r[apb_pkg::ChanW*i +: apb_pkg::ChanW];
    end
  end

  assign dfac = ctl1_r.b_from_c ? (apb_pkg::ChanMax - c2_nxt[apb_pkg::PixW-1 -: apb_pkg::ChanW])
                                : (apb_pkg::ChanMax - ctl1_r.ca);

  always_comb begin
    for (int i = 0; i < apb_pkg::NumChan; i++) begin
      pd2_nxt[i] = apb_pkg::ProdW'(d1_r[apb_pkg::ChanW*i +: apb_pkg::ChanW])
                 * apb_pkg::ProdW'(dfac);
    end
  end

  // ---- stage 3 ----
  always_comb begin
    for (int i = 0; i < apb_pkg::NumChan; i++) begin
      lerp_sum[i] = {1'b0, ps2_r[i]} + {1'b0, pd2_r[i]};
      lerp_pix[apb_pkg::ChanW*i +: apb_pkg::ChanW] = lerp_sum[i][apb_pkg::ProdW-1 -: apb_pkg::ChanW];
      dscaled[apb_pkg::ChanW*i +: apb_pkg::ChanW]  = pd2_r[i][apb_pkg::ProdW-1 -: apb_pkg::ChanW];
    end
  end

  always_comb begin
    unique case (op2_r)
      apb_pkg::OP_PASS_S: res3_nxt = c2_r;
      apb_pkg::OP_PASS_D: res3_nxt = d2_r;
      apb_pkg::OP_LERP:   res3_nxt = lerp_pix;
      apb_pkg::OP_ADD:    res3_nxt = c2_r + dscaled;  // wraps modulo 2^32
      default:            res3_nxt = c2_r;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) begin
      ctl1_r <= ctl1_nxt;
      d1_r   <= in_chan.payload.dest_pixel;
      s1_r   <= s_sel;
      ps1_r  <= ps1_nxt;
    end
    if (rdy2 && v1_r) begin
      op2_r  <= ctl1_r.op;
      eos2_r <= ctl1_r.eos;
      d2_r   <= d1_r;
      c2_r   <= c2_nxt;
      ps2_r  <= ps1_r;
      pd2_r  <= pd2_nxt;
    end
    if (rdy3 && v2_r) begin
      res3_r <= res3_nxt;
      eos3_r <= eos2_r;
    end
  end

  assign out_chan.valid                   = v3_r;
  assign out_chan.payload.result_pixel    = res3_r;
  assign out_chan.payload.end_of_span_out = eos3_r;

  assign stat.v1 = v1_r;
  assign stat.v2 = v2_r;
  assign stat.v3 = v3_r;

endmodule

### rtl/argb_premultiplied_pixel_blender_top.sv
// top level of the premultiplied argb pixel blender: register file, pipeline, checks
// depends on apb_pkg, apb_chan_if and apb_datapath

// Usage
//   in_chan  : one transaction per pixel (dest_pixel, source_pixel, end_of_span)
//   out_chan : one transaction per accepted pixel (result_pixel, end_of_span_out),
//              in the order the pixels were taken
//   cfg_chan : register writes (index, data); always ready, index 0 blend_mode,
//              1 source_kind, 2 solid_color, 3 opacity, other indexes ignored.
//              Write only while no pixel is in flight.
// Path: a pixel taken on in_chan passes the stage-1, stage-2 and result registers
//   in that order before it is offered on out_chan.
// Throughput: one pixel per clock while out_chan is not stalled, set by the three
//   register stages (source scaling, destination scaling, combine) each of which
//   can take a new pixel every cycle.
// Reset (rst_n low at a clock edge): registers return to SourceOver, per-pixel
//   source, solid colour zero, opacity 255; the pipeline is emptied.
// Receiver stall: the result register holds; earlier stages keep filling, so
//   up to three pixels are held and in_chan.ready drops only once all three
//   stages are occupied.

module argb_premultiplied_pixel_blender_top (
  input  logic       clk,
  input  logic       rst_n,
  apb_chan_if.sink   in_chan,
  apb_chan_if.source out_chan,
  apb_chan_if.sink   cfg_chan
);

  apb_pkg::blend_cfg_t cfg_r;
  apb_pkg::pipe_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_mode  <= apb_pkg::RstBlendMode;
      cfg_r.source_kind <= apb_pkg::RstSourceKind;
      cfg_r.solid_color <= apb_pkg::RstSolidColor;
      cfg_r.opacity     <= apb_pkg::RstOpacity;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.payload.index)
        apb_pkg::REG_BLEND_MODE:
          cfg_r.blend_mode  <= apb_pkg::blend_mode_e'(cfg_chan.payload.data[0]);
        apb_pkg::REG_SOURCE_KIND:
          cfg_r.source_kind <= apb_pkg::source_kind_e'(cfg_chan.payload.data[0]);
        apb_pkg::REG_SOLID_COLOR:
          cfg_r.solid_color <= cfg_chan.payload.data[apb_pkg::PixW-1:0];
        apb_pkg::REG_OPACITY:
          cfg_r.opacity     <= cfg_chan.payload.data[apb_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  apb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .stat     (stat)
  );

  // an accepted pixel always lands in the first stage
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> stat.v1)
    else $error("accepted pixel missing from stage 1");

  // with the result register empty the input side must be open
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input blocked while result register empty");

  // all stages full and receiver stalled: nothing more may enter
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.v1 && stat.v2 && stat.v3 && !out_chan.ready |-> !in_chan.ready)
    else $error("pixel accepted into a full stalled pipeline");

  // a stalled result stays offered in the next cycle
  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.v3 && !out_chan.ready |=> stat.v3)
    else $error("stalled result dropped");

endmodule
